/* rtl/core/rgbw_pkg.sv */
// shared types and constants of the rgb to rgbw converter
package rgbw_pkg;

    localparam int CH_W        = 8;
    localparam int WORK_W      = 2 * CH_W;
    localparam int NUM_COLOURS = 3;
    localparam int NUM_LANES   = 4;

    // divider lanes: one per colour plus one for white
    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;
    localparam int LANE_WHITE = 3;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] white_out;
    } pix_out_t;

    typedef struct packed {
        logic [NUM_COLOURS-1:0][CH_W-1:0] colour;
        logic [CH_W-1:0]                  hi;
        logic [CH_W-1:0]                  lo;
    } range_t;

    // work word per lane: upper half partial remainder, lower half dividend/quotient
    typedef struct packed {
        logic                             partial;
        logic [NUM_COLOURS-1:0][CH_W-1:0] colour;
        logic [NUM_COLOURS-1:0][CH_W-1:0] full;
        logic [CH_W-1:0]                  hi;
        logic [CH_W-1:0]                  den;
        logic [NUM_LANES-1:0][WORK_W-1:0] work;
    } div_t;

endpackage

/* rtl/core/rgb_to_rgbw_converter.sv */
// top level of the rgb to rgbw pixel converter
// path from request accepted to m_valid: range, product, divider and output stage registers
// throughput: one pixel per cycle while the sink is ready; the restoring divider is split across pipeline stages
// each stage holds its request until the next one takes it, so a stall loses nothing
// reset: synchronous active-low aresetn clears every stage valid bit, data regs keep state
module rgb_to_rgbw_converter #(
    parameter int DIV_BITS_PER_STAGE = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rgbw_pkg::pix_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rgbw_pkg::pix_out_t m_data
);
    import rgbw_pkg::*;

    // quotients are 8 bits wide, so the divider needs this many stages
    localparam int DIV_STAGES = CH_W / DIV_BITS_PER_STAGE;

    // stage 1 -> stage 2 link
    logic   range_valid;
    logic   range_ready;
    range_t range_data;

    // divider chain: index 0 is the product stage, last index feeds the output stage
    logic [DIV_STAGES:0] div_valid;
    logic [DIV_STAGES:0] div_ready;
    div_t                div_data [DIV_STAGES+1];

    // stage 1: max and min of the three channels
    rgbw_range u_range (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (range_valid),
        .out_ready (range_ready),
        .out_data  (range_data)
    );

    // stage 2: numerators, divisor, full-mode colours, mode flag
    rgbw_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (range_valid),
        .in_ready  (range_ready),
        .in_data   (range_data),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    // divider stages: four lanes in parallel, DIV_BITS_PER_STAGE quotient bits each
    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
        rgbw_div_step #(
            .BITS_PER_STAGE (DIV_BITS_PER_STAGE)
        ) u_div_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (div_valid[i]),
            .in_ready  (div_ready[i]),
            .in_data   (div_data[i]),
            .out_valid (div_valid[i+1]),
            .out_ready (div_ready[i+1]),
            .out_data  (div_data[i+1])
        );
    end

    // final stage: subtract rounded-up reduction, pick mode; black pixel lands in full mode
    rgbw_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_valid[DIV_STAGES]),
        .in_ready  (div_ready[DIV_STAGES]),
        .in_data   (div_data[DIV_STAGES]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    // a finished partial-mode division leaves every remainder below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_valid[DIV_STAGES] && div_data[DIV_STAGES].partial |->
            (div_data[DIV_STAGES].work[LANE_RED][WORK_W-1:CH_W]   < div_data[DIV_STAGES].den) &&
            (div_data[DIV_STAGES].work[LANE_GREEN][WORK_W-1:CH_W] < div_data[DIV_STAGES].den) &&
            (div_data[DIV_STAGES].work[LANE_BLUE][WORK_W-1:CH_W]  < div_data[DIV_STAGES].den) &&
            (div_data[DIV_STAGES].work[LANE_WHITE][WORK_W-1:CH_W] < div_data[DIV_STAGES].den))
    else $error("divider remainder not below divisor");

    // partial extraction always gives less white than the largest channel
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_valid[DIV_STAGES] && div_data[DIV_STAGES].partial |->
            div_data[DIV_STAGES].work[LANE_WHITE][CH_W-1:0] < div_data[DIV_STAGES].hi)
    else $error("partial white not below max channel");

    // with the sink ready the whole pipeline flows
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
    else $error("pipeline stalls with sink ready");

    // reset empties the pipeline
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid && !range_valid && !div_valid[0])
    else $error("valid bits not cleared by reset");

endmodule

/* rtl/core/rgbw_range.sv */
// first stage: largest and smallest channel of the pixel
module rgbw_range (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  rgbw_pkg::pix_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rgbw_pkg::range_t  out_data
);
    import rgbw_pkg::*;

    logic      valid_reg;
    range_t    data_reg;
    range_t    data_next;
    logic [CH_W-1:0] max_rg;
    logic [CH_W-1:0] min_rg;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        max_rg = (in_data.red_in > in_data.green_in) ? in_data.red_in : in_data.green_in;
        min_rg = (in_data.red_in < in_data.green_in) ? in_data.red_in : in_data.green_in;
        data_next.colour[LANE_RED]   = in_data.red_in;
        data_next.colour[LANE_GREEN] = in_data.green_in;
        data_next.colour[LANE_BLUE]  = in_data.blue_in;
        data_next.hi = (max_rg > in_data.blue_in) ? max_rg : in_data.blue_in;
        data_next.lo = (min_rg < in_data.blue_in) ? min_rg : in_data.blue_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/core/rgbw_mult.sv */
// second stage: products, divisor and full-extraction colours
module rgbw_mult (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  rgbw_pkg::range_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output rgbw_pkg::div_t   out_data
);
    import rgbw_pkg::*;

    logic  valid_reg;
    div_t  data_reg;
    div_t  data_next;
    logic [CH_W-1:0]   den;
    logic [CH_W-1:0]   gap;
    logic [WORK_W-1:0] prod;
    logic [WORK_W:0]   num_up;
    logic [CH_W:0]     twice;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        den = in_data.hi - in_data.lo;
        data_next         = '0;
        data_next.colour  = in_data.colour;
        data_next.hi      = in_data.hi;
        data_next.den     = den;
        // 2m < M decides between partial and full white extraction
        data_next.partial = {in_data.lo, 1'b0} < {1'b0, in_data.hi};
        data_next.work[LANE_WHITE] = WORK_W'(in_data.lo) * WORK_W'(in_data.hi);
        for (int c = 0; c < NUM_COLOURS; c++) begin
            gap    = in_data.hi - in_data.colour[c];
            prod   = WORK_W'(in_data.lo) * WORK_W'(gap);
            // bias by den - 1 so the truncating divide rounds up
            num_up = {1'b0, prod} + {{(WORK_W-CH_W+1){1'b0}}, den}
                     - {{WORK_W{1'b0}}, 1'b1};
            data_next.work[c] = num_up[WORK_W-1:0];
            twice  = {in_data.colour[c], 1'b0};
            data_next.full[c] = (twice > {1'b0, in_data.hi})
                                ? (twice[CH_W-1:0] - in_data.hi) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/core/rgbw_div_step.sv */
// restoring divider stage: BITS_PER_STAGE quotient bits for all four lanes
module rgbw_div_step #(
    parameter int BITS_PER_STAGE = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  rgbw_pkg::div_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output rgbw_pkg::div_t out_data
);
    import rgbw_pkg::*;

    logic  valid_reg;
    div_t  data_reg;
    div_t  data_next;
    logic [WORK_W-1:0] w;
    logic [CH_W:0]     trial;
    logic [CH_W:0]     diff;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        data_next = in_data;
        for (int l = 0; l < NUM_LANES; l++) begin
            w = in_data.work[l];
            for (int s = 0; s < BITS_PER_STAGE; s++) begin
                trial = {w[WORK_W-1:CH_W], w[CH_W-1]};
                diff  = trial - {1'b0, in_data.den};
                if (trial >= {1'b0, in_data.den}) begin
                    w = {diff[CH_W-1:0], w[CH_W-2:0], 1'b1};
                end else begin
                    w = {trial[CH_W-1:0], w[CH_W-2:0], 1'b0};
                end
            end
            data_next.work[l] = w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/core/rgbw_out.sv */
// last stage: colour reduction and choice between the two extraction modes
module rgbw_out (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  rgbw_pkg::div_t     in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rgbw_pkg::pix_out_t out_data
);
    import rgbw_pkg::*;

    logic     valid_reg;
    pix_out_t data_reg;
    pix_out_t data_next;
    logic [NUM_COLOURS-1:0][CH_W-1:0] res;
    logic [CH_W-1:0] sub;
    logic [CH_W-1:0] white;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        for (int c = 0; c < NUM_COLOURS; c++) begin
            sub = in_data.work[c][CH_W-1:0];
            if (in_data.partial) begin
                res[c] = (sub > in_data.colour[c]) ? '0 : (in_data.colour[c] - sub);
            end else begin
                res[c] = in_data.full[c];
            end
        end
        white = in_data.partial ? in_data.work[LANE_WHITE][CH_W-1:0] : in_data.hi;
        data_next.red_out   = res[LANE_RED];
        data_next.green_out = res[LANE_GREEN];
        data_next.blue_out  = res[LANE_BLUE];
        data_next.white_out = white;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
